// File: design/ppa_pkg.sv
package ppa_pkg;

    localparam int CH_W  = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W = NUM_CH * CH_W;
    localparam int Q8_W  = 27;

    localparam logic [3:0] MODE_PASS     = 4'd0;
    localparam logic [3:0] MODE_BRIGHT   = 4'd1;
    localparam logic [3:0] MODE_CONTRAST = 4'd2;
    localparam logic [3:0] MODE_SOLARISE = 4'd3;
    localparam logic [3:0] MODE_BALANCE  = 4'd4;
    localparam logic [3:0] MODE_INVERT   = 4'd5;
    localparam logic [3:0] MODE_GREY     = 4'd6;
    localparam logic [3:0] MODE_GREY_INV = 4'd7;
    localparam logic [3:0] MODE_SEPIA    = 4'd8;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_OFFSET   = 2'd1;
    localparam logic [1:0] REG_BAL_CH   = 2'd2;
    localparam logic [1:0] REG_CONTRAST = 2'd3;

    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam logic [8:0]  BAL_FRAC   = 9'd13;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic [8:0]  offset;
        logic [1:0]  balance_channel;
        logic [15:0] contrast_gain;
    } ppa_cfg_t;

    // Q8.8 sepia weighted sum (Q0.8 weights) for one output channel
    function automatic logic [15:0] sepia_sum(input logic [1:0] ch, input pixel_t px);
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] s;
        r = 16'(px[CH_RED]);
        g = 16'(px[CH_GREEN]);
        b = 16'(px[CH_BLUE]);
        case (ch)
            CH_RED:   s = r * 16'd102 + g * 16'd115 + b * 16'd26;
            CH_GREEN: s = r * 16'd90 + g * 16'd90 + b * 16'd26;
            default:  s = r * 16'd51 + g * 16'd64 + b * 16'd51;
        endcase
        return s;
    endfunction

    function automatic logic signed [Q8_W-1:0] to_q8(input logic [CH_W-1:0] x);
        return $signed({{(Q8_W-CH_W-8){1'b0}}, x, 8'd0});
    endfunction

endpackage

// File: design/pixel_point_adjust.sv
// Throughput: one pixel per cycle; three pipeline stages, stalls only on m_tready.
// Stages: input register with channel peak, per-mode Q.8 value with the
// contrast multiplier, saturation into the output register.
// Reset (synchronous, aresetn low) empties the pipeline and restores
// mode 0, offset 0, balance_channel 0, contrast_gain 256.
module pixel_point_adjust
    import ppa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]  mode_reg;
    logic [8:0]  offset_reg;
    logic [1:0]  bal_ch_reg;
    logic [15:0] gain_reg;
    logic        wr_en;
    ppa_cfg_t    cfg;
    pixel_t      m_pix;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_PASS;
            offset_reg <= '0;
            bal_ch_reg <= CH_RED;
            gain_reg   <= GAIN_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_MODE:     mode_reg   <= pwdata[3:0];
                REG_OFFSET:   offset_reg <= pwdata[8:0];
                REG_BAL_CH:   bal_ch_reg <= pwdata[1:0];
                REG_CONTRAST: gain_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:     prdata = {28'd0, mode_reg};
            REG_OFFSET:   prdata = {23'd0, offset_reg};
            REG_BAL_CH:   prdata = {30'd0, bal_ch_reg};
            REG_CONTRAST: prdata = {16'd0, gain_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.mode            = mode_reg;
    assign cfg.offset          = offset_reg;
    assign cfg.balance_channel = bal_ch_reg;
    assign cfg.contrast_gain   = gain_reg;

    ppa_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_pix    (pixel_t'(s_tdata)),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_pix    (m_pix)
    );

    assign m_tdata = PIX_W'(m_pix);

`ifndef NO_ASSERTIONS
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output side is ready");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_mode_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && paddr[3:2] == REG_MODE) |=> mode_reg == $past(pwdata[3:0]))
        else $error("mode register write lost");

    a_gain_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && paddr[3:2] == REG_CONTRAST) |=> gain_reg == $past(pwdata[15:0]))
        else $error("contrast gain write lost");
`endif

endmodule

// File: design/ppa_pipe.sv
module ppa_pipe
    import ppa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  ppa_cfg_t         cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pixel_t           s_pix,
    output logic             m_tvalid,
    input  logic             m_tready,
    output pixel_t           m_pix
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    pixel_t          px_reg;
    logic [CH_W-1:0] peak_reg;
    logic [CH_W-1:0] peak_next;

    logic signed [NUM_CH-1:0][Q8_W-1:0] q_reg;
    logic signed [NUM_CH-1:0][Q8_W-1:0] q_next;

    pixel_t out_reg;
    pixel_t out_next;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v3_reg;
    assign m_pix    = out_reg;

    always_comb begin
        peak_next = s_pix[CH_RED];
        if (s_pix[CH_GREEN] > peak_next) begin
            peak_next = s_pix[CH_GREEN];
        end
        if (s_pix[CH_BLUE] > peak_next) begin
            peak_next = s_pix[CH_BLUE];
        end
    end

    // stage 2: every mode mapped onto a signed Q.8 value
    always_comb begin
        logic signed [10:0]     c11;
        logic signed [10:0]     off11;
        logic signed [Q8_W-1:0] c27;
        logic signed [Q8_W-1:0] off27;
        logic signed [Q8_W-1:0] gain27;
        logic signed [Q8_W-1:0] d27;
        logic signed [10:0]     sum11;
        logic [CH_W-1:0]        c;
        for (int i = 0; i < NUM_CH; i++) begin
            c      = px_reg[i];
            c11    = $signed({3'd0, c});
            off11  = $signed({{2{cfg.offset[8]}}, cfg.offset});
            c27    = $signed({{(Q8_W-CH_W){1'b0}}, c});
            off27  = $signed({{(Q8_W-9){cfg.offset[8]}}, cfg.offset});
            gain27 = $signed({{(Q8_W-16){1'b0}}, cfg.contrast_gain});
            d27    = c27 - Q8_W'(128);
            sum11  = c11;
            q_next[i] = to_q8(c);
            case (cfg.mode)
                MODE_BRIGHT: begin
                    sum11     = c11 + off11;
                    q_next[i] = $signed({{(Q8_W-19){sum11[10]}}, sum11, 8'd0});
                end
                MODE_CONTRAST: begin
                    q_next[i] = gain27 * d27 + Q8_W'(32768);
                end
                MODE_SOLARISE: begin
                    if (c11 < off11) begin
                        q_next[i] = to_q8(~c);
                    end
                end
                MODE_BALANCE: begin
                    if (cfg.balance_channel == 2'(i)) begin
                        q_next[i] = to_q8(c) - off27 * $signed({{(Q8_W-9){1'b0}}, BAL_FRAC});
                    end else begin
                        sum11     = c11 - off11;
                        q_next[i] = $signed({{(Q8_W-19){sum11[10]}}, sum11, 8'd0});
                    end
                end
                MODE_INVERT:   q_next[i] = to_q8(~c);
                MODE_GREY:     q_next[i] = to_q8(peak_reg);
                MODE_GREY_INV: q_next[i] = to_q8(~peak_reg);
                MODE_SEPIA: begin
                    q_next[i] = $signed({{(Q8_W-16){1'b0}}, sepia_sum(2'(i), px_reg)});
                end
                default: ;
            endcase
        end
    end

    // stage 3: clamp and drop the fraction
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            if (q_reg[i][Q8_W-1]) begin
                out_next[i] = '0;
            end else if (|q_reg[i][Q8_W-2:16]) begin
                out_next[i] = '1;
            end else begin
                out_next[i] = q_reg[i][15:8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy1) begin
            px_reg   <= s_pix;
            peak_reg <= peak_next;
        end
        if (v1_reg && rdy2) begin
            q_reg <= q_next;
        end
        if (v2_reg && rdy3) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ppa_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // red_in[7:0], green_in[15:8], blue_in[23:16]

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // red_out[7:0], green_out[15:8], blue_out[23:16]

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pixel_point_adjust dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the adjustment registers
    logic [3:0]        adj_mode = MODE_PASS;
    logic signed [8:0] adj_offset = '0;
    logic [1:0]        adj_bal_ch = CH_RED;
    logic [15:0]       adj_gain = GAIN_RESET;

    pixel_t expected_pixels[$];
    int     fail_count = 0;
    int     pixels_sent = 0;

    // sender burst shaping
    int burst_left = 0;
    int gap_max = 0;
    int burst_max = 1;

    // receiver stall shaping
    int stall_pct = 0;
    int ready_run = 0;
    int ready_run_max = 8;
    bit ready_level = 1'b1;

    function automatic logic [7:0] clamp8(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic logic [7:0] clamp_q8(input int v);
        if (v < 0) return 8'd0;
        if (v > 65535) return 8'd255;
        return v[15:8];
    endfunction

    function automatic pixel_t adjust_pixel(input pixel_t px);
        pixel_t res;
        int     peak;
        int     c;
        int     off;
        int     gain;
        int     r;
        int     g;
        int     b;
        off  = adj_offset;
        gain = adj_gain;
        r    = px[CH_RED];
        g    = px[CH_GREEN];
        b    = px[CH_BLUE];
        peak = r;
        if (g > peak) peak = g;
        if (b > peak) peak = b;
        for (int i = 0; i < NUM_CH; i++) begin
            c = px[i];
            case (adj_mode)
                MODE_BRIGHT:   res[i] = clamp8(c + off);
                MODE_CONTRAST: res[i] = clamp_q8(gain * (c - 128) + 128 * 256);
                MODE_SOLARISE: res[i] = (c < off) ? 8'(255 - c) : 8'(c);
                MODE_BALANCE: begin
                    if (i == int'(adj_bal_ch))
                        res[i] = clamp_q8(c * 256 - off * 13);
                    else
                        res[i] = clamp8(c - off);
                end
                MODE_INVERT:   res[i] = 8'(255 - c);
                MODE_GREY:     res[i] = 8'(peak);
                MODE_GREY_INV: res[i] = 8'(255 - peak);
                MODE_SEPIA: begin
                    case (i)
                        0:       res[i] = clamp8((102 * r + 115 * g + 26 * b) >> 8);
                        1:       res[i] = clamp8((90 * r + 90 * g + 26 * b) >> 8);
                        default: res[i] = clamp8((51 * r + 64 * g + 51 * b) >> 8);
                    endcase
                end
                default:       res[i] = 8'(c);
            endcase
        end
        return res;
    endfunction

    // result checker and receiver stall pattern
    always @(posedge aclk) begin
        pixel_t want;
        pixel_t got;
        string  ch_name [3];
        ch_name = '{"red", "green", "blue"};
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_pixels.size() == 0) begin
                if (fail_count < 10)
                    $display("%0t: unexpected result %06h", $realtime, got);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                for (int i = 0; i < NUM_CH; i++) begin
                    if (got[i] !== want[i]) begin
                        if (fail_count < 10)
                            $display("%0t: %s mismatch, expected %02h, got %02h (pixel %06h)",
                                     $realtime, ch_name[i], want[i], got[i], got);
                        fail_count++;
                    end
                end
            end
        end
        if (ready_run == 0) begin
            ready_level = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
            ready_run = $urandom_range(ready_run_max, 1);
        end
        ready_run--;
        m_tready <= ready_level;
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MODE:     adj_mode = data[3:0];
            REG_OFFSET:   adj_offset = data[8:0];
            REG_BAL_CH:   adj_bal_ch = data[1:0];
            REG_CONTRAST: adj_gain = data[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic stop_stream();
        s_tvalid   <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        stop_stream();
        @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [3:0] mode, input logic [8:0] off,
                             input logic [1:0] bal_ch, input logic [15:0] gain);
        wait_drained();
        apb_write(REG_MODE, ($urandom & 32'hFFFF_FFF0) | 32'(mode));
        apb_write(REG_OFFSET, ($urandom & 32'hFFFF_FE00) | 32'(off));
        apb_write(REG_BAL_CH, ($urandom & 32'hFFFF_FFFC) | 32'(bal_ch));
        apb_write(REG_CONTRAST, ($urandom & 32'hFFFF_0000) | 32'(gain));
    endtask

    task automatic send_pixel(input pixel_t px);
        int     gap;
        pixel_t want;
        if (burst_left == 0) begin
            gap = $urandom_range(gap_max);
            burst_left = $urandom_range(burst_max, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        want = adjust_pixel(px);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        expected_pixels = {expected_pixels, want};
        burst_left--;
        pixels_sent++;
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd127;
            3: return 8'd128;
            default: return 8'($urandom);
        endcase
    endfunction

    // reset values of all registers, pass mode
    task automatic test_reset_config();
        gap_max = 0;
        burst_max = 1;
        stall_pct = 0;
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
    endtask

    task automatic test_each_mode();
        configure(MODE_BRIGHT, 9'h0FF, CH_RED, GAIN_RESET);
        send_pixel(24'h80FF01);
        configure(MODE_BRIGHT, 9'h100, CH_RED, GAIN_RESET);
        send_pixel(24'hFF00FF);
        configure(MODE_CONTRAST, 9'h000, CH_RED, 16'd0);
        send_pixel(24'h80FF00);
        configure(MODE_CONTRAST, 9'h000, CH_RED, 16'hFFFF);
        send_pixel(24'h81807F);
        configure(MODE_SOLARISE, 9'h080, CH_RED, GAIN_RESET);
        send_pixel(24'h81807F);
        configure(MODE_SOLARISE, 9'h101, CH_RED, GAIN_RESET);
        send_pixel(24'h01FF00);
        configure(MODE_BALANCE, 9'h0FF, CH_RED, GAIN_RESET);
        send_pixel(24'hFFFF10);
        configure(MODE_BALANCE, 9'h101, CH_BLUE, GAIN_RESET);
        send_pixel(24'hF0FF00);
        // no channel selected: full strength on all three
        configure(MODE_BALANCE, 9'h064, 2'd3, GAIN_RESET);
        send_pixel(24'hFF6465);
        configure(MODE_INVERT, 9'h000, CH_RED, GAIN_RESET);
        send_pixel(24'h5AFF00);
        configure(MODE_GREY, 9'h000, CH_RED, GAIN_RESET);
        send_pixel(24'hFFA010);
        send_pixel(24'h2010C0);
        configure(MODE_GREY_INV, 9'h000, CH_RED, GAIN_RESET);
        send_pixel(24'h10C020);
        configure(MODE_SEPIA, 9'h000, CH_RED, GAIN_RESET);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        configure(4'd15, 9'h0FF, CH_GREEN, 16'hFFFF);
        send_pixel(24'h563412);
    endtask

    task automatic test_random_settings(input int target);
        logic [3:0]  mode;
        logic [8:0]  off;
        logic [15:0] gain;
        int          n;
        int          pause_at;
        int          phase;
        pixel_t      px;
        phase = 0;
        while (pixels_sent < target) begin
            mode = ($urandom_range(99) < 85) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
            case ($urandom_range(9))
                0: off = 9'h0FF;
                1: off = 9'h101;
                2: off = 9'h100;
                3: off = 9'h000;
                default: off = 9'($urandom);
            endcase
            case ($urandom_range(9))
                0: gain = 16'd0;
                1: gain = 16'hFFFF;
                2: gain = GAIN_RESET;
                3: gain = 16'd33152;
                4: gain = 16'($urandom);
                default: gain = 16'($urandom_range(33152));
            endcase
            configure(mode, off, 2'($urandom_range(3)), gain);
            case ($urandom_range(3))
                0: begin gap_max = 0; burst_max = 1;  stall_pct = 0;  end
                1: begin gap_max = 1; burst_max = 16; stall_pct = 20; end
                2: begin gap_max = 3; burst_max = 6;  stall_pct = 50; end
                default: begin gap_max = 6; burst_max = 3; stall_pct = 75; end
            endcase
            n = $urandom_range(90, 30);
            pause_at = (phase == 0 || $urandom_range(3) == 0) ? $urandom_range(n - 1) : -1;
            for (int k = 0; k < n; k++) begin
                if (k == pause_at)
                    wait_drained();
                if ($urandom_range(3) == 0) begin
                    for (int i = 0; i < NUM_CH; i++) px[i] = pick_channel();
                end else begin
                    px = 24'($urandom);
                end
                send_pixel(px);
            end
            phase++;
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_config();
        test_each_mode();
        test_random_settings(1720);
        stop_stream();
        @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: pixel_point_adjust.f
design/ppa_pkg.sv
design/ppa_pipe.sv
design/pixel_point_adjust.sv
sim/tb_top.sv
